FILE: rtl/core/tkrs_pkg.sv
// Shared constants, types and helpers of the two-key radix sorter.
`default_nettype none
package tkrs_pkg;
    localparam int MaxRecords = 64;
    localparam int AddrW      = $clog2(MaxRecords);
    localparam int CntW       = AddrW + 1;
    localparam int FieldW     = 32;
    localparam int RecW       = 3 * FieldW;
    localparam int DigitW     = 8;
    localparam int PassSelW   = $clog2(FieldW / DigitW);
    localparam int PassW      = PassSelW + 2;
    localparam logic [PassW-1:0] PassEnd = PassW'(2 * (FieldW / DigitW));

    localparam logic [1:0] CfgKeyOrder = 2'd0;
    localparam logic [1:0] CfgValueEn  = 2'd1;
    localparam logic [1:0] CfgRankEn   = 2'd2;

    typedef struct packed {
        logic clear;
        logic valid;
    } t_rank_ctl;

    // Digit of one key for the digit position sel, least significant first.
    function automatic logic [DigitW-1:0] key_digit(input logic [FieldW-1:0] key,
                                                    input logic [PassSelW-1:0] sel);
        logic [FieldW-1:0] sh;
        sh = key >> (sel * DigitW);
        return sh[DigitW-1:0];
    endfunction
endpackage
`default_nettype wire

FILE: rtl/core/tkrs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tkrs_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/core/tkrs_rank_unit.sv
// Shared compare-and-count unit: finds the stable scatter position of one record.
`default_nettype none
module tkrs_rank_unit import tkrs_pkg::*; (
    input  wire logic              i_clk,
    input  wire t_rank_ctl         i_ctl,
    input  wire logic [DigitW-1:0] i_digit_i,
    input  wire logic [AddrW-1:0]  i_idx_i,
    input  wire logic [DigitW-1:0] i_digit_j,
    input  wire logic [CntW-1:0]   i_idx_j,
    output logic      [AddrW-1:0]  o_pos
);
    logic w_before;

    // A record lands after every smaller digit and after equal digits seen earlier.
    assign w_before = (i_digit_j < i_digit_i) ||
                      ((i_digit_j == i_digit_i) && (i_idx_j < {1'b0, i_idx_i}));

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            o_pos <= '0;
        end else if (i_ctl.valid && w_before) begin
            o_pos <= o_pos + AddrW'(1);
        end
    end
endmodule
`default_nettype wire

FILE: rtl/core/two_key_lsd_radix_sort_core.sv
// Two-key LSD radix sorter: loads a record set, sorts it between two RAMs, streams it out.
// Loading accepts a record whenever s_axis_tvalid is high. Each enabled digit pass places
// the N stored records one by one (one shared compare unit scanning the record RAM), with
// up to eight passes; each output record is then read, registered and held until taken.
// i_rst_n is synchronous and active low; it clears the sequencer and counts and sets the
// configuration to its defaults, while the record RAMs keep undefined contents.
`default_nettype none
module two_key_lsd_radix_sort_core import tkrs_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [RecW-1:0]   s_axis_tdata,  // value_key, rank_key, payload
    input  wire logic              s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic      [RecW-1:0]   m_axis_tdata,  // sorted_value, sorted_rank, sorted_payload
    output logic                   m_axis_tlast,
    output logic                   m_axis_tuser,  // overflow
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic              i_cfg_data
);
    typedef enum logic [7:0] {
        S_LOAD  = 8'b00000001,
        S_PASS  = 8'b00000010,
        S_RDI   = 8'b00000100,
        S_LATI  = 8'b00001000,
        S_SCAN  = 8'b00010000,
        S_WRITE = 8'b00100000,
        S_ERD   = 8'b01000000,
        S_EMIT  = 8'b10000000
    } t_state;

    t_state r_state, n_state;
    logic r_key_order, r_val_en, r_rank_en;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic             r_drop, n_drop;
    logic [AddrW-1:0] r_i, n_i;
    logic [CntW-1:0]  r_j, n_j, r_jd;
    logic             r_cvld, n_cvld;
    logic [PassW-1:0] r_pass, n_pass;
    logic             r_sel, n_sel;
    logic [RecW-1:0]  r_rec;
    logic             r_emit_last;
    logic             r_ovld, n_ovld;

    logic [AddrW-1:0] w_raddr, w_waddr, w_pos;
    logic [RecW-1:0]  w_wdata, w_rd_a, w_rd_b, w_cur;
    logic             w_we_a, w_we_b, w_use_rank, w_pass_en, w_is_last_i;
    logic [FieldW-1:0] w_key_i, w_key_j;
    t_rank_ctl        w_ctl;

    assign w_cur       = r_sel ? w_rd_b : w_rd_a;
    assign w_use_rank  = r_key_order ? ~r_pass[PassW-2] : r_pass[PassW-2];
    assign w_pass_en   = w_use_rank ? r_rank_en : r_val_en;
    assign w_key_i     = w_use_rank ? r_rec[2*FieldW-1:FieldW] : r_rec[FieldW-1:0];
    assign w_key_j     = w_use_rank ? w_cur[2*FieldW-1:FieldW] : w_cur[FieldW-1:0];
    assign w_is_last_i = (CntW'(r_i) + CntW'(1)) == r_cnt;

    assign s_axis_tready = (r_state == S_LOAD);
    // Registers only change while records are being loaded, never during a sort.
    assign o_cfg_ready   = (r_state == S_LOAD);
    assign m_axis_tvalid = r_ovld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_order <= 1'b0;
            r_val_en    <= 1'b1;
            r_rank_en   <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CfgKeyOrder: r_key_order <= i_cfg_data;
                CfgValueEn:  r_val_en    <= i_cfg_data;
                CfgRankEn:   r_rank_en   <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_drop  = r_drop;
        n_i     = r_i;
        n_j     = r_j;
        n_cvld  = 1'b0;
        n_pass  = r_pass;
        n_sel   = r_sel;
        n_ovld  = r_ovld;
        w_raddr = r_i;
        w_waddr = r_cnt[AddrW-1:0];
        w_wdata = s_axis_tdata;
        w_we_a  = 1'b0;
        w_we_b  = 1'b0;
        w_ctl   = '{clear: 1'b0, valid: r_cvld};
        case (r_state)
            S_LOAD: begin
                if (s_axis_tvalid) begin
                    if (r_cnt < CntW'(MaxRecords)) begin
                        w_we_a = 1'b1;
                        n_cnt  = r_cnt + CntW'(1);
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (s_axis_tlast) begin
                        n_pass  = '0;
                        n_sel   = 1'b0;
                        n_state = S_PASS;
                    end
                end
            end
            S_PASS: begin
                n_i = '0;
                if (r_pass == PassEnd) begin
                    n_state = S_ERD;
                end else if (!w_pass_en) begin
                    n_pass = r_pass + PassW'(1);
                end else begin
                    n_state = S_RDI;
                end
            end
            S_RDI: n_state = S_LATI;
            S_LATI: begin
                w_ctl.clear = 1'b1;
                n_j         = '0;
                n_state     = S_SCAN;
            end
            S_SCAN: begin
                w_raddr = r_j[AddrW-1:0];
                if (r_j == r_cnt) begin
                    n_state = S_WRITE;
                end else begin
                    n_cvld = 1'b1;
                    n_j    = r_j + CntW'(1);
                end
            end
            S_WRITE: begin
                w_waddr = w_pos;
                w_wdata = r_rec;
                w_we_a  = r_sel;
                w_we_b  = ~r_sel;
                n_i     = r_i + AddrW'(1);
                if (w_is_last_i) begin
                    n_sel   = ~r_sel;
                    n_pass  = r_pass + PassW'(1);
                    n_state = S_PASS;
                end else begin
                    n_state = S_RDI;
                end
            end
            S_ERD: n_state = S_EMIT;
            S_EMIT: begin
                if (!r_ovld) begin
                    n_ovld = 1'b1;
                end else if (m_axis_tready) begin
                    n_ovld = 1'b0;
                    n_i    = r_i + AddrW'(1);
                    if (r_emit_last) begin
                        n_cnt   = '0;
                        n_drop  = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_ERD;
                    end
                end
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_drop  <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_cvld  <= 1'b0;
            r_pass  <= '0;
            r_sel   <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_drop  <= n_drop;
            r_i     <= n_i;
            r_j     <= n_j;
            r_cvld  <= n_cvld;
            r_pass  <= n_pass;
            r_sel   <= n_sel;
            r_ovld  <= n_ovld;
        end
    end

    // Payload registers: the record under placement and the output item.
    always_ff @(posedge i_clk) begin
        r_jd <= r_j;
        if (r_state == S_LATI) begin
            r_rec <= w_cur;
        end
        if (r_state == S_EMIT && !r_ovld) begin
            m_axis_tdata <= w_cur;
            r_emit_last  <= w_is_last_i;
        end
    end

    assign m_axis_tlast = r_emit_last;
    assign m_axis_tuser = r_drop;

    tkrs_rank_unit u_rank (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl),
        .i_digit_i (key_digit(w_key_i, r_pass[PassSelW-1:0])),
        .i_idx_i   (r_i),
        .i_digit_j (key_digit(w_key_j, r_pass[PassSelW-1:0])),
        .i_idx_j   (r_jd),
        .o_pos     (w_pos)
    );

    tkrs_ram #(.Width(RecW), .Depth(MaxRecords)) u_buf_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_a)
    );

    tkrs_ram #(.Width(RecW), .Depth(MaxRecords)) u_buf_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_b)
    );
endmodule
`default_nettype wire

FILE: rtl/core/tkrs_checker.sv
// Port-level checks of the radix sorter, bound to the top level.
`default_nettype none
module tkrs_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic s_axis_tvalid,
    input wire logic s_axis_tready,
    input wire logic s_axis_tlast,
    input wire logic m_axis_tvalid,
    input wire logic m_axis_tready,
    input wire logic m_axis_tlast
);
    // Loading and emitting never overlap.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("load and emit overlap");

    // A last input item always closes the load phase.
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("still loading after last item");

    // After the final output item is taken the block returns to loading.
    a_emit_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (s_axis_tready && !m_axis_tvalid))
        else $error("no return to loading after final item");

    // An offered output item stays until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("output item withdrawn");
endmodule

bind two_key_lsd_radix_sort_core tkrs_checker u_tkrs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire
